### rtl/sdk_pkg.sv
`default_nettype none
package sdk_pkg;

  // One drive command.
  typedef struct packed {
    logic signed [15:0] strafe_x;
    logic signed [15:0] strafe_y;
    logic signed [15:0] rotation;
    logic signed [15:0] heading;
  } cmd_t;

  // One set of wheel results.
  typedef struct packed {
    logic [16:0]        fr_speed;
    logic [16:0]        fl_speed;
    logic [16:0]        br_speed;
    logic [16:0]        bl_speed;
    logic signed [15:0] fr_angle;
    logic signed [15:0] fl_angle;
    logic signed [15:0] br_angle;
    logic signed [15:0] bl_angle;
    logic               hold_angles;
  } res_t;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_LENGTH = 3'd0,
    REG_WIDTH  = 3'd1,
    REG_SCALE  = 3'd2,
    REG_INVERT = 3'd3,
    REG_FIELD  = 3'd4
  } cfg_reg_e;

  // Spacing ratio sequencer states.
  typedef enum logic [1:0] {
    RAT_IDLE,
    RAT_DIV,
    RAT_SQRT
  } rat_state_e;

  localparam int RATIO_W = 19;

  // Spacing ratios and whether they are up to date.
  typedef struct packed {
    logic               ready;
    logic [RATIO_W-1:0] ratio_l;
    logic [RATIO_W-1:0] ratio_w;
  } ratio_t;

  // Arctangent of 2^-i, 2^32 units per turn.
  localparam int ATAN_N = 24;
  localparam logic [31:0] ATAN_TAB [0:ATAN_N-1] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
    32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  // Inverse CORDIC gain in Q30.
  localparam logic [29:0] GAIN_INV  = 30'd652032874;
  localparam logic [16:0] SPEED_MAX = 17'd92682;
  localparam logic [15:0] SCALE_ONE = 16'd32768;

  // Negation that saturates minus one to the largest positive value.
  function automatic logic signed [15:0] neg_sat(input logic signed [15:0] v);
    return (v == 16'sh8000) ? 16'sh7FFF : -v;
  endfunction

endpackage
`default_nettype wire

### rtl/swerve_drive_kinematics.sv
`default_nettype none
// Channel   Handshake             Payload
// in_       in_valid / in_ready   in_data   (sdk_pkg::cmd_t)
// out_      out_valid / out_ready out_data  (sdk_pkg::res_t)
// cfg_      cfg_we                cfg_index, cfg_wdata
//
// One item per cycle while in_ready is high, front end first, then wheel units.
// After reset, and after a write to the length or width register, in_ready
// stays low while the spacing ratios are divided and rooted.
// A stall at the output freezes the whole pipeline; the output register is its
// last stage.
module swerve_drive_kinematics #(
  parameter int DATA_WIDTH    = 16,
  parameter int CORDIC_STAGES = 16
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  sdk_pkg::cmd_t   in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output sdk_pkg::res_t   out_data,
  input  logic            cfg_we,
  input  logic [2:0]      cfg_index,
  input  logic [15:0]     cfg_wdata
);
  import sdk_pkg::*;

  localparam int DW    = DATA_WIDTH;
  localparam int CS    = CORDIC_STAGES;
  localparam int PW    = DW + 3;
  localparam int FL    = CS + 5;
  localparam int SL    = PW + 4;
  localparam int AL    = CS + 2;
  localparam int WL    = (SL > AL) ? SL : AL;
  localparam int TOTAL = FL + WL;

  logic [11:0] len_r, wid_r;
  logic [15:0] scale_r;
  logic        inv_r, fo_r;
  logic        restart_r;
  logic        geo_wr;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r   <= 12'd1;
      wid_r   <= 12'd1;
      scale_r <= SCALE_ONE;
      inv_r   <= 1'b0;
      fo_r    <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_LENGTH: len_r   <= cfg_wdata[11:0];
        REG_WIDTH:  wid_r   <= cfg_wdata[11:0];
        REG_SCALE:  scale_r <= cfg_wdata;
        REG_INVERT: inv_r   <= cfg_wdata[0];
        REG_FIELD:  fo_r    <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // A geometry change restarts the ratio computation in the next cycle, through restart_r.
  assign geo_wr = cfg_we && (cfg_index == REG_LENGTH || cfg_index == REG_WIDTH);
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      restart_r <= 1'b1;
    end else begin
      restart_r <= geo_wr;
    end
  end

  ratio_t rat;
  sdk_ratio u_ratio (
    .clk     (clk),
    .rst_n   (rst_n),
    .len     (len_r),
    .wid     (wid_r),
    .restart (restart_r),
    .rat     (rat)
  );

  // Pipeline enable and valid bits.
  logic             en;
  logic [TOTAL-1:0] vld_r;
  assign out_valid = vld_r[TOTAL-1];
  assign en        = !out_valid || out_ready;
  assign in_ready  = en && rat.ready && !geo_wr;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[TOTAL-2:0], in_valid && in_ready};
    end
  end

  // Zero-motion flag (strafe and rotation all zero) travels with the item.
  logic zero_in, zero_out;
  assign zero_in = (in_data.strafe_x == 16'sd0) && (in_data.strafe_y == 16'sd0) &&
                   (in_data.rotation == 16'sd0);
  sdk_delay #(.WIDTH(1), .DEPTH(TOTAL)) u_zero (
    .clk (clk),
    .en  (en),
    .d   (zero_in),
    .q   (zero_out)
  );

  logic [15:0] scale_e;
  assign scale_e = (scale_r > SCALE_ONE) ? SCALE_ONE : scale_r;

  logic signed [PW-1:0] ca, cb, cc, cd;
  sdk_front #(.DW(DW), .CS(CS)) u_front (
    .clk     (clk),
    .en      (en),
    .cmd     (in_data),
    .invert  (inv_r),
    .field   (fo_r),
    .ratio_l (rat.ratio_l),
    .ratio_w (rat.ratio_w),
    .a_o     (ca),
    .b_o     (cb),
    .c_o     (cc),
    .d_o     (cd)
  );

  logic [16:0] spd_fr, spd_fl, spd_br, spd_bl;
  logic [15:0] ang_fr, ang_fl, ang_br, ang_bl;

  sdk_wheel #(.DW(DW), .CS(CS)) u_fr (
    .clk (clk), .en (en), .p (cb), .q (cd), .scale (scale_e),
    .speed (spd_fr), .angle (ang_fr)
  );
  sdk_wheel #(.DW(DW), .CS(CS)) u_fl (
    .clk (clk), .en (en), .p (cb), .q (cc), .scale (scale_e),
    .speed (spd_fl), .angle (ang_fl)
  );
  sdk_wheel #(.DW(DW), .CS(CS)) u_br (
    .clk (clk), .en (en), .p (ca), .q (cd), .scale (scale_e),
    .speed (spd_br), .angle (ang_br)
  );
  sdk_wheel #(.DW(DW), .CS(CS)) u_bl (
    .clk (clk), .en (en), .p (ca), .q (cc), .scale (scale_e),
    .speed (spd_bl), .angle (ang_bl)
  );

  // A zero command gives zero speeds and held angles.
  always_comb begin
    out_data.fr_speed    = zero_out ? 17'd0 : spd_fr;
    out_data.fl_speed    = zero_out ? 17'd0 : spd_fl;
    out_data.br_speed    = zero_out ? 17'd0 : spd_br;
    out_data.bl_speed    = zero_out ? 17'd0 : spd_bl;
    out_data.fr_angle    = zero_out ? 16'sd0 : $signed(ang_fr);
    out_data.fl_angle    = zero_out ? 16'sd0 : $signed(ang_fl);
    out_data.br_angle    = zero_out ? 16'sd0 : $signed(ang_br);
    out_data.bl_angle    = zero_out ? 16'sd0 : $signed(ang_bl);
    out_data.hold_angles = zero_out;
  end

`ifndef ASSERT_OFF
  a_geo_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    geo_wr |=> !in_ready)
    else $error("input accepted while spacing ratios recompute");

  a_stall_freezes: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> $stable(vld_r))
    else $error("pipeline moved during output stall");

  a_speed_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.fr_speed <= SPEED_MAX && out_data.fl_speed <= SPEED_MAX &&
                   out_data.br_speed <= SPEED_MAX && out_data.bl_speed <= SPEED_MAX))
    else $error("wheel speed above saturation limit");
`endif

endmodule
`default_nettype wire

### rtl/sdk_delay.sv
`default_nettype none
module sdk_delay #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1
) (
  input  logic             clk,
  input  logic             en,
  input  logic [WIDTH-1:0] d,
  output logic [WIDTH-1:0] q
);

  // Shift line that advances with the pipeline enable.
  generate
    if (DEPTH == 0) begin : g_none
      assign q = d;
    end else begin : g_line
      logic [WIDTH-1:0] tap_r [0:DEPTH-1];
      always_ff @(posedge clk) begin
        if (en) begin
          tap_r[0] <= d;
          for (int k = 1; k < DEPTH; k++) begin
            tap_r[k] <= tap_r[k-1];
          end
        end
      end
      assign q = tap_r[DEPTH-1];
    end
  endgenerate

endmodule
`default_nettype wire

### rtl/sdk_ratio.sv
`default_nettype none
module sdk_ratio (
  input  logic            clk,
  input  logic            rst_n,
  input  logic [11:0]     len,
  input  logic [11:0]     wid,
  input  logic            restart,
  output sdk_pkg::ratio_t rat
);
  import sdk_pkg::*;

  rat_state_e         state_r, state_nxt;
  logic               sel_r;
  logic [5:0]         cnt_r;
  logic [24:0]        drem_r;
  logic [37:0]        q_r;
  logic [20:0]        srem_r;
  logic [18:0]        root_r;
  logic [RATIO_W-1:0] ratio_l_r, ratio_w_r;

  logic [11:0] len_e, wid_e;
  logic [23:0] lsq, wsq;
  logic [24:0] den;
  logic [25:0] dtry, ddiff;
  logic        dge;
  logic [22:0] stmp, strial, sdiff;
  logic        sge;
  logic        last_div, last_sqrt;

  // A zero spacing counts as one.
  assign len_e = (len == 12'd0) ? 12'd1 : len;
  assign wid_e = (wid == 12'd0) ? 12'd1 : wid;
  assign lsq   = len_e * len_e;
  assign wsq   = wid_e * wid_e;
  assign den   = {1'b0, lsq} + {1'b0, wsq};

  // One quotient bit of nsq * 2^38 / den per cycle.
  assign dtry  = {drem_r, 1'b0};
  assign ddiff = dtry - {1'b0, den};
  assign dge   = (dtry >= {1'b0, den});

  // One root bit of the quotient per cycle.
  assign stmp   = {srem_r, q_r[37:36]};
  assign strial = {2'b00, root_r, 2'b01};
  assign sdiff  = stmp - strial;
  assign sge    = (stmp >= strial);

  assign last_div  = (cnt_r == 6'd37);
  assign last_sqrt = (cnt_r == 6'd18);

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= RAT_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state: divide, then root, once for each ratio.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      RAT_IDLE: state_nxt = RAT_IDLE;
      RAT_DIV:  if (last_div) state_nxt = RAT_SQRT;
      RAT_SQRT: if (last_sqrt) state_nxt = sel_r ? RAT_IDLE : RAT_DIV;
      default:  state_nxt = RAT_IDLE;
    endcase
    if (restart) state_nxt = RAT_DIV;
  end

  // Control counters.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_r <= 1'b0;
      cnt_r <= 6'd0;
    end else if (restart) begin
      sel_r <= 1'b0;
      cnt_r <= 6'd0;
    end else begin
      case (state_r)
        RAT_DIV: cnt_r <= last_div ? 6'd0 : cnt_r + 6'd1;
        RAT_SQRT: begin
          cnt_r <= last_sqrt ? 6'd0 : cnt_r + 6'd1;
          if (last_sqrt) sel_r <= 1'b1;
        end
        default: cnt_r <= 6'd0;
      endcase
    end
  end

  // Datapath of the divider and the root.
  always_ff @(posedge clk) begin
    if (restart) begin
      drem_r <= {1'b0, lsq};
      q_r    <= '0;
    end else begin
      case (state_r)
        RAT_DIV: begin
          drem_r <= dge ? ddiff[24:0] : dtry[24:0];
          q_r    <= {q_r[36:0], dge};
          if (last_div) begin
            srem_r <= '0;
            root_r <= '0;
          end
        end
        RAT_SQRT: begin
          q_r    <= {q_r[35:0], 2'b00};
          srem_r <= sge ? sdiff[20:0] : stmp[20:0];
          root_r <= {root_r[17:0], sge};
          if (last_sqrt) begin
            if (sel_r) begin
              ratio_w_r <= {root_r[17:0], sge};
            end else begin
              ratio_l_r <= {root_r[17:0], sge};
              drem_r    <= {1'b0, wsq};
              q_r       <= '0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  assign rat.ready   = (state_r == RAT_IDLE) && !restart;
  assign rat.ratio_l = ratio_l_r;
  assign rat.ratio_w = ratio_w_r;

endmodule
`default_nettype wire

### rtl/sdk_front.sv
`default_nettype none
module sdk_front #(
  parameter int DW = 16,
  parameter int CS = 16
) (
  input  logic                         clk,
  input  logic                         en,
  input  sdk_pkg::cmd_t                cmd,
  input  logic                         invert,
  input  logic                         field,
  input  logic [sdk_pkg::RATIO_W-1:0]  ratio_l,
  input  logic [sdk_pkg::RATIO_W-1:0]  ratio_w,
  output logic signed [DW+2:0]         a_o,
  output logic signed [DW+2:0]         b_o,
  output logic signed [DW+2:0]         c_o,
  output logic signed [DW+2:0]         d_o
);
  import sdk_pkg::*;

  localparam int IW  = DW + 1;
  localparam int CW  = DW + 4;
  localparam int PW  = DW + 3;
  localparam int UP  = (DW >= 15) ? DW - 15 : 0;
  localparam int DN  = (DW < 15) ? 15 - DW : 0;
  localparam int GPW = CW + 31;
  localparam int OPW = IW + RATIO_W + 1;

  localparam logic signed [GPW-1:0] GRND = {{(GPW-30){1'b0}}, 1'b1, 29'b0};
  localparam logic signed [OPW-1:0] ORND = {{(OPW-19){1'b0}}, 1'b1, 18'b0};

  // Q1.15 into the internal format, floor when narrowing.
  function automatic logic signed [IW-1:0] to_int(input logic signed [15:0] v);
    logic signed [DW+15:0] w;
    w = {{DW{v[15]}}, v};
    w = w <<< UP;
    w = w >>> DN;
    return w[IW-1:0];
  endfunction

  logic signed [IW-1:0] x0_r, y0_r, t0_r;
  logic signed [31:0]   z0_r;
  logic                 fo0_r;

  // Input conditioning: negate translation, optional turn inversion.
  always_ff @(posedge clk) begin
    if (en) begin
      x0_r  <= to_int(neg_sat(cmd.strafe_x));
      y0_r  <= to_int(neg_sat(cmd.strafe_y));
      t0_r  <= to_int(invert ? neg_sat(cmd.rotation) : cmd.rotation);
      z0_r  <= {cmd.heading, 16'h0000};
      fo0_r <= field;
    end
  end

  logic signed [CW-1:0] rx_r [0:CS];
  logic signed [CW-1:0] ry_r [0:CS];
  logic signed [31:0]   rz_r [0:CS];
  logic signed [CW-1:0] xe, ye;

  assign xe = {{3{x0_r[IW-1]}}, x0_r};
  assign ye = {{3{y0_r[IW-1]}}, y0_r};

  // Half-turn pre-rotation for headings beyond a quarter turn.
  always_ff @(posedge clk) begin
    if (en) begin
      if (z0_r > 32'sh4000_0000) begin
        rx_r[0] <= -xe;
        ry_r[0] <= -ye;
        rz_r[0] <= z0_r - 32'sh8000_0000;
      end else if (z0_r < 32'shC000_0000) begin
        rx_r[0] <= -xe;
        ry_r[0] <= -ye;
        rz_r[0] <= z0_r + 32'sh8000_0000;
      end else begin
        rx_r[0] <= xe;
        ry_r[0] <= ye;
        rz_r[0] <= z0_r;
      end
    end
  end

  // Rotation-mode CORDIC, one micro-rotation per stage.
  generate
    for (genvar i = 0; i < CS; i++) begin : g_rot
      always_ff @(posedge clk) begin
        if (en) begin
          if (rz_r[i] >= 0) begin
            rx_r[i+1] <= rx_r[i] - (ry_r[i] >>> i);
            ry_r[i+1] <= ry_r[i] + (rx_r[i] >>> i);
            rz_r[i+1] <= rz_r[i] - $signed(ATAN_TAB[i]);
          end else begin
            rx_r[i+1] <= rx_r[i] + (ry_r[i] >>> i);
            ry_r[i+1] <= ry_r[i] - (rx_r[i] >>> i);
            rz_r[i+1] <= rz_r[i] + $signed(ATAN_TAB[i]);
          end
        end
      end
    end
  endgenerate

  // Gain correction.
  logic signed [GPW-1:0] gx_r, gy_r, gxs, gys;
  always_ff @(posedge clk) begin
    if (en) begin
      gx_r <= rx_r[CS] * $signed({1'b0, GAIN_INV});
      gy_r <= ry_r[CS] * $signed({1'b0, GAIN_INV});
    end
  end
  assign gxs = (gx_r + GRND) >>> 30;
  assign gys = (gy_r + GRND) >>> 30;

  // Unrotated translation, aligned with the gain stage.
  logic [2*IW:0]        raw_d;
  logic signed [IW-1:0] xd, yd;
  logic                 fod;
  sdk_delay #(.WIDTH(2*IW+1), .DEPTH(CS+2)) u_raw (
    .clk (clk),
    .en  (en),
    .d   ({fo0_r, x0_r, y0_r}),
    .q   (raw_d)
  );
  assign fod = raw_d[2*IW];
  assign xd  = $signed(raw_d[2*IW-1:IW]);
  assign yd  = $signed(raw_d[IW-1:0]);

  logic signed [PW-1:0] xr_r, yr_r;
  always_ff @(posedge clk) begin
    if (en) begin
      xr_r <= fod ? gxs[PW-1:0] : {{2{xd[IW-1]}}, xd};
      yr_r <= fod ? gys[PW-1:0] : {{2{yd[IW-1]}}, yd};
    end
  end

  // Rotation offsets t * L/r and t * W/r.
  logic signed [OPW-1:0] opl_r, opw_r, opls, opws;
  logic signed [PW-1:0]  ol_r, ow_r;
  always_ff @(posedge clk) begin
    if (en) begin
      opl_r <= t0_r * $signed({1'b0, ratio_l});
      opw_r <= t0_r * $signed({1'b0, ratio_w});
      ol_r  <= opls[PW-1:0];
      ow_r  <= opws[PW-1:0];
    end
  end
  assign opls = (opl_r + ORND) >>> 19;
  assign opws = (opw_r + ORND) >>> 19;

  logic [2*PW-1:0]      off_d;
  logic signed [PW-1:0] old, owd;
  sdk_delay #(.WIDTH(2*PW), .DEPTH(CS+1)) u_off (
    .clk (clk),
    .en  (en),
    .d   ({ol_r, ow_r}),
    .q   (off_d)
  );
  assign old = $signed(off_d[2*PW-1:PW]);
  assign owd = $signed(off_d[PW-1:0]);

  // Per-pair components.
  always_ff @(posedge clk) begin
    if (en) begin
      a_o <= xr_r - old;
      b_o <= xr_r + old;
      c_o <= yr_r - owd;
      d_o <= yr_r + owd;
    end
  end

endmodule
`default_nettype wire

### rtl/sdk_wheel.sv
`default_nettype none
module sdk_wheel #(
  parameter int DW = 16,
  parameter int CS = 16
) (
  input  logic                clk,
  input  logic                en,
  input  logic signed [DW+2:0] p,
  input  logic signed [DW+2:0] q,
  input  logic [15:0]         scale,
  output logic [16:0]         speed,
  output logic [15:0]         angle
);
  import sdk_pkg::*;

  localparam int PW = DW + 3;
  localparam int NB = PW;
  localparam int RW = 2 * NB;
  localparam int AW = DW + 5;
  localparam int MW = NB + 17;
  localparam int SL = NB + 4;
  localparam int AL = CS + 2;
  localparam int WL = (SL > AL) ? SL : AL;

  localparam logic [MW-1:0] SRND = {{(MW-DW){1'b0}}, 1'b1, {(DW-1){1'b0}}};

  // Squares of both components.
  logic signed [2*PW-1:0] pp_r, qq_r;
  always_ff @(posedge clk) begin
    if (en) begin
      pp_r <= p * p;
      qq_r <= q * q;
    end
  end

  logic [RW-1:0]   rad_r  [0:NB];
  logic [NB+1:0]   rem_r  [0:NB];
  logic [NB-1:0]   root_r [0:NB];

  // Sum of squares opens the root pipeline.
  always_ff @(posedge clk) begin
    if (en) begin
      rad_r[0]  <= pp_r + qq_r;
      rem_r[0]  <= '0;
      root_r[0] <= '0;
    end
  end

  // Integer square root, one result bit per stage.
  generate
    for (genvar i = 0; i < NB; i++) begin : g_sqrt
      logic [NB+3:0] tmp, trial, diff;
      logic          ge;
      assign tmp   = {rem_r[i], rad_r[i][RW-1:RW-2]};
      assign trial = {2'b00, root_r[i], 2'b01};
      assign diff  = tmp - trial;
      assign ge    = (tmp >= trial);
      always_ff @(posedge clk) begin
        if (en) begin
          rad_r[i+1]  <= {rad_r[i][RW-3:0], 2'b00};
          rem_r[i+1]  <= ge ? diff[NB+1:0] : tmp[NB+1:0];
          root_r[i+1] <= {root_r[i][NB-2:0], ge};
        end
      end
    end
  endgenerate

  // Speed scaling with rounding and saturation.
  logic [MW-1:0] mag_r, msum;
  logic [16:0]   sp_r;
  assign msum = (mag_r + SRND) >> DW;
  always_ff @(posedge clk) begin
    if (en) begin
      mag_r <= {{(MW-NB){1'b0}}, root_r[NB]} * {{(MW-16){1'b0}}, scale};
      sp_r  <= (msum > {{(MW-17){1'b0}}, SPEED_MAX}) ? SPEED_MAX : msum[16:0];
    end
  end

  logic signed [AW-1:0] ax_r [0:CS];
  logic signed [AW-1:0] ay_r [0:CS];
  logic [31:0]          az_r [0:CS];
  logic signed [AW-1:0] pe, qe;

  assign pe = {{2{p[PW-1]}}, p};
  assign qe = {{2{q[PW-1]}}, q};

  // Half-turn pre-rotation when the second component is negative.
  always_ff @(posedge clk) begin
    if (en) begin
      if (q < 0) begin
        ax_r[0] <= -qe;
        ay_r[0] <= -pe;
        az_r[0] <= 32'h8000_0000;
      end else begin
        ax_r[0] <= qe;
        ay_r[0] <= pe;
        az_r[0] <= 32'h0000_0000;
      end
    end
  end

  // Vectoring-mode CORDIC; a zero y residue holds.
  generate
    for (genvar i = 0; i < CS; i++) begin : g_vec
      always_ff @(posedge clk) begin
        if (en) begin
          if (ay_r[i] > 0) begin
            ax_r[i+1] <= ax_r[i] + (ay_r[i] >>> i);
            ay_r[i+1] <= ay_r[i] - (ax_r[i] >>> i);
            az_r[i+1] <= az_r[i] + ATAN_TAB[i];
          end else if (ay_r[i] < 0) begin
            ax_r[i+1] <= ax_r[i] - (ay_r[i] >>> i);
            ay_r[i+1] <= ay_r[i] + (ax_r[i] >>> i);
            az_r[i+1] <= az_r[i] - ATAN_TAB[i];
          end else begin
            ax_r[i+1] <= ax_r[i];
            ay_r[i+1] <= ay_r[i];
            az_r[i+1] <= az_r[i];
          end
        end
      end
    end
  endgenerate

  // Angle over pi, rounded to 16 bits.
  logic [15:0] an_r;
  always_ff @(posedge clk) begin
    if (en) begin
      an_r <= az_r[CS][31:16] + {15'd0, az_r[CS][15]};
    end
  end

  // Align both results to the longer path.
  sdk_delay #(.WIDTH(17), .DEPTH(WL-SL)) u_spd (
    .clk (clk),
    .en  (en),
    .d   (sp_r),
    .q   (speed)
  );
  sdk_delay #(.WIDTH(16), .DEPTH(WL-AL)) u_ang (
    .clk (clk),
    .en  (en),
    .d   (an_r),
    .q   (angle)
  );

endmodule
`default_nettype wire
